>>> rtl/core/mode_s_binary_frame_deframer_assert.svh
// Assertion macros used by the deframer top level.
`ifndef MODE_S_BINARY_FRAME_DEFRAMER_ASSERT_SVH
`define MODE_S_BINARY_FRAME_DEFRAMER_ASSERT_SVH

// The condition must hold at every rising clock edge outside reset.
`define MSBD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define MSBD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/msbd_pkg.sv
// Shared types, constants and helpers for the binary frame deframer.
package msbd_pkg;

    localparam int unsigned MsbdQueueDepth = 4;

    localparam logic [7:0] SYNC_BYTE      = 8'h1A;
    localparam logic [7:0] TYPE_MODE_AC   = 8'h31;
    localparam logic [7:0] TYPE_SHORT     = 8'h32;
    localparam logic [7:0] TYPE_LONG      = 8'h33;
    localparam logic [3:0] STAMP_LAST_IDX = 4'd5;

    localparam int unsigned MODEAC_BYTES = 2;
    localparam int unsigned SHORT_BYTES  = 7;
    localparam int unsigned LONG_BYTES   = 14;

    typedef enum logic [1:0] {
        KIND_MODE_AC = 2'd0,
        KIND_SHORT   = 2'd1,
        KIND_LONG    = 2'd2
    } frame_kind_t;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_TYPE    = 3'd1,
        PH_STAMP   = 3'd2,
        PH_SIGNAL  = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [47:0] time_stamp;
        logic [7:0]  signal_byte;
        logic [7:0]  payload_byte;
        logic [3:0]  byte_index;
        logic        last_byte;
    } result_t;

    // Index of the final payload byte for a frame kind.
    function automatic logic [3:0] last_index(input logic [1:0] kind);
        logic [3:0] idx;
        case (kind)
            KIND_MODE_AC: idx = 4'(MODEAC_BYTES - 1);
            KIND_SHORT:   idx = 4'(SHORT_BYTES - 1);
            default:      idx = 4'(LONG_BYTES - 1);
        endcase
        return idx;
    endfunction

endpackage

>>> rtl/core/msbd_front.sv
// Front end: sync hunt, escape removal and frame field capture.
module msbd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              byte_valid,
    input  logic [7:0]        byte_data,
    output logic              push,
    output msbd_pkg::result_t push_data
);
    import msbd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        esc_reg, esc_next;
    logic [1:0]  kind_reg, kind_next;
    logic        discard_reg, discard_next;
    logic [47:0] stamp_reg, stamp_next;
    logic [7:0]  signal_reg, signal_next;
    logic [3:0]  count_reg, count_next;
    logic        ac_en_reg;
    logic        is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            esc_reg     <= 1'b0;
            kind_reg    <= 2'd0;
            discard_reg <= 1'b0;
            count_reg   <= 4'd0;
            ac_en_reg   <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            esc_reg     <= esc_next;
            kind_reg    <= kind_next;
            discard_reg <= discard_next;
            count_reg   <= count_next;
            if (cfg_wr_en) begin
                ac_en_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        stamp_reg  <= stamp_next;
        signal_reg <= signal_next;
    end

    assign is_last = (count_reg == last_index(kind_reg));

    always_comb begin
        phase_next   = phase_reg;
        esc_next     = esc_reg;
        kind_next    = kind_reg;
        discard_next = discard_reg;
        stamp_next   = stamp_reg;
        signal_next  = signal_reg;
        count_next   = count_reg;
        push         = 1'b0;

        push_data.frame_kind   = kind_reg;
        push_data.time_stamp   = stamp_reg;
        push_data.signal_byte  = signal_reg;
        push_data.payload_byte = byte_data;
        push_data.byte_index   = count_reg;
        push_data.last_byte    = is_last;

        if (byte_valid) begin
            if (esc_reg) begin
                // The byte after an in-frame sync value is dropped.
                esc_next = 1'b0;
            end else begin
                case (phase_reg)
                    PH_TYPE: begin
                        if (byte_data == SYNC_BYTE) begin
                            phase_next = PH_TYPE;
                        end else if (byte_data == TYPE_MODE_AC || byte_data == TYPE_SHORT ||
                                     byte_data == TYPE_LONG) begin
                            kind_next    = 2'(byte_data - TYPE_MODE_AC);
                            discard_next = (byte_data == TYPE_MODE_AC) && !ac_en_reg;
                            stamp_next   = '0;
                            count_next   = 4'd0;
                            phase_next   = PH_STAMP;
                        end else begin
                            phase_next = PH_HUNT;
                        end
                    end
                    PH_STAMP: begin
                        stamp_next = {stamp_reg[39:0], byte_data};
                        esc_next   = (byte_data == SYNC_BYTE);
                        if (count_reg == STAMP_LAST_IDX) begin
                            count_next = 4'd0;
                            phase_next = PH_SIGNAL;
                        end else begin
                            count_next = count_reg + 4'd1;
                        end
                    end
                    PH_SIGNAL: begin
                        signal_next = byte_data;
                        esc_next    = (byte_data == SYNC_BYTE);
                        count_next  = 4'd0;
                        phase_next  = PH_PAYLOAD;
                    end
                    PH_PAYLOAD: begin
                        esc_next = (byte_data == SYNC_BYTE);
                        push     = !discard_reg;
                        if (is_last) begin
                            count_next = 4'd0;
                            phase_next = PH_HUNT;
                        end else begin
                            count_next = count_reg + 4'd1;
                        end
                    end
                    default: begin
                        phase_next = (byte_data == SYNC_BYTE) ? PH_TYPE : PH_HUNT;
                    end
                endcase
            end
        end
    end

endmodule

>>> rtl/core/msbd_queue.sv
// Small word queue between the front end and the output stage.
module msbd_queue #(
    parameter int unsigned DEPTH = msbd_pkg::MsbdQueueDepth
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  msbd_pkg::result_t               push_data,
    input  logic                            pop,
    output msbd_pkg::result_t               head_data,
    output logic                            not_empty,
    output logic                            not_full,
    output logic [$clog2(DEPTH + 1) - 1:0]  fill
);
    import msbd_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    result_t         entry_reg [DEPTH];
    logic [PW - 1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW - 1:0] count_reg;
    logic            do_push, do_pop;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg < CW'(DEPTH));
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head_data = entry_reg[rd_ptr_reg];
    assign fill      = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/msbd_back.sv
// Output stage: registered result word presented to the downstream side.
module msbd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              have_word,
    input  msbd_pkg::result_t head_data,
    output logic              pop,
    input  logic              out_ready,
    output logic              out_valid,
    output msbd_pkg::result_t out_data
);
    import msbd_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // Load a new word whenever the register is empty or being drained.
    assign pop       = have_word && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= head_data;
        end
    end

endmodule

>>> rtl/core/mode_s_binary_frame_deframer.sv
// Top level of the binary receiver-stream frame deframer.
//
//   Channel   Direction  Payload
//   s_        in         tdata[7:0] raw stream byte
//   m_        out        tdata payload fields, tuser frame kind, tlast final payload byte
//   cfg_      in         wr_data: Mode A/C pass enable, written when wr_en is high
//
// One byte word is taken per clock while s_tready is high. The front end decides
// everything about a byte in the cycle it is accepted and writes at most one result
// word into the queue at that same edge; the output register loads the word once it
// reaches the queue head and the register is empty or being drained. s_tready is low
// only while the queue is full, so input stalls only when the output side has been
// stalled long enough to fill the queue. Reset is synchronous and active low; it returns
// the parser to sync hunting and empties the queue and output register.
`include "mode_s_binary_frame_deframer_assert.svh"

module mode_s_binary_frame_deframer #(
    parameter int unsigned QUEUE_DEPTH = msbd_pkg::MsbdQueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [47:0] time_stamp, [55:48] signal_byte,
                                   // [63:56] payload_byte, [67:64] byte_index, rest zero
    output logic [1:0]  m_tuser,   // [1:0] frame_kind
    output logic        m_tlast    // last_byte
);
    import msbd_pkg::*;

    logic                             in_accept;
    logic                             q_push;
    result_t                          q_push_data;
    logic                             q_pop;
    result_t                          q_head;
    logic                             q_not_empty;
    logic                             q_not_full;
    logic [$clog2(QUEUE_DEPTH + 1) - 1:0] q_fill;
    result_t                          out_word;
    logic                             fill_ok;
    logic                             last_ok;

    // A byte is accepted whenever the queue has room for the word it might produce.
    assign s_tready  = q_not_full;
    assign in_accept = s_tvalid && s_tready;

    msbd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_valid  (in_accept),
        .byte_data   (s_tdata),
        .push        (q_push),
        .push_data   (q_push_data)
    );

    msbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head_data (q_head),
        .not_empty (q_not_empty),
        .not_full  (q_not_full),
        .fill      (q_fill)
    );

    msbd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .have_word (q_not_empty),
        .head_data (q_head),
        .pop       (q_pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_word)
    );

    // Pack the result word onto the stream ports.
    assign m_tdata = {4'b0000, out_word.byte_index, out_word.payload_byte,
                      out_word.signal_byte, out_word.time_stamp};
    assign m_tuser = out_word.frame_kind;
    assign m_tlast = out_word.last_byte;

    assign fill_ok = (q_fill <= ($clog2(QUEUE_DEPTH + 1))'(QUEUE_DEPTH));
    assign last_ok = (m_tdata[67:64] == last_index(m_tuser));

    // The queue never holds more words than it has entries.
    `MSBD_ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, fill_ok, "queue fill exceeds depth")

    // The front end only produces a word when the queue has room for it.
    `MSBD_ASSERT_IMPLIES(a_push_room, aclk, aresetn, q_push, q_not_full, "push into full queue")

    // A word marked last carries the final index of its frame kind.
    `MSBD_ASSERT_IMPLIES(a_last_index, aclk, aresetn, m_tvalid && m_tlast, last_ok, "bad last idx")

endmodule
